[hw/rtl/sgd_pkg.sv]
`timescale 1ns / 1ps

package sgd_pkg;

  // field and store widths
  localparam int unsigned MAG_W      = 64;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W  = $clog2(MAG_W);
  localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned SEP_W      = 24;
  localparam int unsigned SEP_LEN_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  // character codes
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] MINUS_SIGN = 8'h2D;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN   = 1'b1;
  localparam logic [SEP_W-1:0]     SEP_BYTES_RST = 24'd44;
  localparam logic [SEP_LEN_W-1:0] SEP_LEN_RST   = 2'd1;

  // remaining digit count modulo the group size, at load
  localparam logic [1:0] REM_MOD3_INIT = 2'(NUM_DIGITS % 3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_SEP
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit_sign;
    logic emit_digit;
    logic emit_sep;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic top_zero;
    logic rem_one;
    logic neg;
    logic out_free;
    logic group_next;
    logic sep_last;
  } status_t;

endpackage

[hw/rtl/sgd_in_if.sv]
`timescale 1ns / 1ps

interface sgd_in_if import sgd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MAG_W-1:0] number_value;

  modport source (output valid, output number_value, input ready);
  modport sink   (input valid, input number_value, output ready);
endinterface

[hw/rtl/sgd_out_if.sv]
`timescale 1ns / 1ps

interface sgd_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

[hw/rtl/sgd_ctrl.sv]
`timescale 1ns / 1ps

module sgd_ctrl import sgd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status.last_bit) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!(status.top_zero && !status.rem_one)) begin
          state_nxt = status.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status.out_free) begin
          if (status.rem_one) begin
            state_nxt = ST_IDLE;
          end else if (status.group_next) begin
            state_nxt = ST_SEP;
          end
        end
      end
      ST_SEP: begin
        if (status.out_free && status.sep_last) begin
          state_nxt = ST_DIGIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.conv_step  = 1'b1;
      ST_SKIP:  cmd.skip_step  = status.top_zero && !status.rem_one;
      ST_SIGN:  cmd.emit_sign  = status.out_free;
      ST_DIGIT: cmd.emit_digit = status.out_free;
      ST_SEP:   cmd.emit_sep   = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/sgd_datapath.sv]
`timescale 1ns / 1ps

module sgd_datapath import sgd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [MAG_W-1:0] number_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SEP_W-1:0]        cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [7:0]              text_byte,
  output logic                    last_byte,
  input  cmd_t                    cmd,
  output status_t                 status
);

  logic [SEP_W-1:0]     sep_bytes_r;
  logic [SEP_LEN_W-1:0] sep_len_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic [MAG_W-1:0]     mag_r;
  logic [BCD_W-1:0]     bcd_r;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt_r;
  logic [REM_W-1:0]     rem_r;
  logic [1:0]           rem_mod3_r;
  logic [1:0]           sep_idx_r;
  logic                 neg_r;
  logic [3:0]           top_digit;
  logic [7:0]           sep_byte;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 emit_last;

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign emit      = cmd.emit_sign || cmd.emit_digit || cmd.emit_sep;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                    : bcd_r[4*d +: 4];
    end
  end

  // separator byte for the current position
  always_comb begin
    case (sep_idx_r)
      2'd0:    sep_byte = sep_bytes_r[7:0];
      2'd1:    sep_byte = sep_bytes_r[15:8];
      default: sep_byte = sep_bytes_r[23:16];
    endcase
  end

  // byte to send
  always_comb begin
    emit_byte = DIGIT_ZERO | {4'd0, top_digit};
    emit_last = 1'b0;
    if (cmd.emit_sign) begin
      emit_byte = MINUS_SIGN;
    end else if (cmd.emit_sep) begin
      emit_byte = sep_byte;
    end else begin
      emit_last = (rem_r == REM_W'(1));
    end
  end

  // configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes_r <= SEP_BYTES_RST;
      sep_len_r   <= SEP_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_SEP_BYTES) begin
        sep_bytes_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_SEP_LEN) begin
        sep_len_r <= cfg_wdata[SEP_LEN_W-1:0];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // conversion and output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
    if (cmd.load) begin
      neg_r      <= number_value[MAG_W-1];
      mag_r      <= number_value[MAG_W-1] ? (~number_value + MAG_W'(1)) : number_value;
      bcd_r      <= '0;
      bit_cnt_r  <= '0;
      rem_r      <= REM_W'(NUM_DIGITS);
      rem_mod3_r <= REM_MOD3_INIT;
      sep_idx_r  <= '0;
    end
    if (cmd.conv_step) begin
      bcd_r     <= {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
      mag_r     <= {mag_r[MAG_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + BIT_CNT_W'(1);
    end
    // dropping a leading zero or sending a digit both consume the top digit
    if (cmd.skip_step || cmd.emit_digit) begin
      bcd_r      <= {bcd_r[BCD_W-5:0], 4'd0};
      rem_r      <= rem_r - REM_W'(1);
      rem_mod3_r <= (rem_mod3_r == 2'd0) ? 2'd2 : rem_mod3_r - 2'd1;
    end
    if (cmd.emit_sep) begin
      sep_idx_r <= status.sep_last ? 2'd0 : sep_idx_r + 2'd1;
    end
  end

  // status to the controller
  always_comb begin
    status.last_bit   = (bit_cnt_r == BIT_CNT_W'(MAG_W - 1));
    status.top_zero   = (top_digit == 4'd0);
    status.rem_one    = (rem_r == REM_W'(1));
    status.neg        = neg_r;
    status.out_free   = !out_valid_r || out_ready;
    // the digit after this one starts a group
    status.group_next = (rem_mod3_r == 2'd1) && (rem_r != REM_W'(1)) &&
                        (sep_len_r != '0);
    status.sep_last   = (sep_idx_r == sep_len_r - 2'd1);
  end

  assign out_valid = out_valid_r;
  assign text_byte = out_byte_r;
  assign last_byte = out_last_r;

endmodule

[hw/rtl/signed_int_to_grouped_decimal.sv]
`timescale 1ns / 1ps

// channel  dir  payload                          handshake
// in_ch    in   number_value[63:0] signed        valid / ready
// out_ch   out  text_byte[7:0], last_byte        valid / ready
// cfg      in   cfg_index[0], cfg_wdata[23:0]    cfg_we, no wait
//
// one item takes a load, 64 shift-add steps in the binary to bcd converter,
// a step for each of the 20 digits that either drops a leading zero or sends
// the digit, a step to find the first digit, and a step per sign or separator
// byte
// the input is taken only between items; the output register lets the next
// item load while the final byte still waits
// a stalled output holds the byte sequencer; reset is synchronous, active low

module signed_int_to_grouped_decimal import sgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  sgd_in_if.sink               in_ch,
  sgd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEP_W-1:0]     cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  sgd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // converter, byte selection and output register
  sgd_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .number_value (in_ch.number_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .text_byte    (out_ch.text_byte),
    .last_byte    (out_ch.last_byte),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
